/* design/ldd_pkg.sv */
`timescale 1ns / 1ps

package ldd_pkg;

   // field and arithmetic widths
   localparam int COUNT_BITS    = 16;
   localparam int FRACTION_BITS = 15;
   localparam int GENO_BITS     = 2;
   localparam int DP_BITS       = 16;
   localparam int VC_BITS       = 16;
   localparam int CELLS         = 9;
   localparam int CELL_BITS     = $clog2(CELLS);

   // haplotype weights reach 9*cmax, marginals 18*cmax
   localparam int WGT_BITS  = COUNT_BITS + 5;
   localparam int PROD_BITS = 2 * WGT_BITS;
   localparam int SUM_BITS  = COUNT_BITS + 4;
   localparam int NX_BITS   = (SUM_BITS > VC_BITS) ? SUM_BITS : VC_BITS;
   localparam int MAG_BITS  = FRACTION_BITS + 1;
   localparam int STEP_BITS = $clog2(FRACTION_BITS + 2);

   // genotype code for a missing call
   localparam logic [GENO_BITS-1:0] GENO_MISSING = GENO_BITS'(3);

   typedef logic [GENO_BITS-1:0]       geno_type;
   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [WGT_BITS-1:0]        wgt_type;
   typedef logic [PROD_BITS-1:0]       prod_type;
   typedef logic [SUM_BITS-1:0]        sum_type;
   typedef logic [MAG_BITS-1:0]        mag_type;
   typedef logic signed [DP_BITS-1:0]  dp_type;
   typedef logic [VC_BITS-1:0]         vc_type;

endpackage

/* design/ldd_req_if.sv */
`timescale 1ns / 1ps

interface ldd_req_if import ldd_pkg::*; ();
   logic     valid;
   logic     ready;
   geno_type genotype_a;
   geno_type genotype_b;
   logic     last_sample;

   modport source (output valid, output genotype_a, output genotype_b, output last_sample,
                   input ready);
   modport sink (input valid, input genotype_a, input genotype_b, input last_sample,
                 output ready);
endinterface

/* design/ldd_rsp_if.sv */
`timescale 1ns / 1ps

interface ldd_rsp_if import ldd_pkg::*; ();
   logic   valid;
   logic   ready;
   dp_type d_prime;
   logic   degenerate;
   vc_type valid_count;

   modport source (output valid, output d_prime, output degenerate, output valid_count,
                   input ready);
   modport sink (input valid, input d_prime, input degenerate, input valid_count,
                 output ready);
endinterface

/* design/linkage_disequilibrium_dprime.sv */
`timescale 1ns / 1ps

// Lewontin D' between two biallelic markers. Each req transfer carries one sample
// (two genotype codes, 3 = missing); samples with both calls present bump one of nine
// saturating joint counters, one sample per cycle. The sample flagged last_sample is
// counted too, then the block stops taking samples while it forms the haplotype weights
// and marginals, runs four products through one shared multiplier, picks Lewontin's
// Dmax and divides with a restoring divider that retires one quotient bit per cycle.
// After a final sample the result is loaded once the computation ends and the
// previous result has left rsp. D' comes out in Q1.15, rounded to nearest with ties
// away from zero; degenerate flags an empty sample set or a zero normaliser (d_prime
// then reads 0). The counters clear when the result is loaded, so the next marker
// pair starts fresh.
module linkage_disequilibrium_dprime import ldd_pkg::*; (
   input logic        clock,
   input logic        reset,
   ldd_req_if.sink    req_chan,
   ldd_rsp_if.source  rsp_chan
);

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_WGT    = 4'd1;
   localparam logic [3:0] ST_MUL_A  = 4'd2;
   localparam logic [3:0] ST_MUL_B  = 4'd3;
   localparam logic [3:0] ST_SIGN   = 4'd4;
   localparam logic [3:0] ST_MUL_X  = 4'd5;
   localparam logic [3:0] ST_MUL_Y  = 4'd6;
   localparam logic [3:0] ST_DMAX   = 4'd7;
   localparam logic [3:0] ST_CHECK  = 4'd8;
   localparam logic [3:0] ST_DIV    = 4'd9;
   localparam logic [3:0] ST_FINISH = 4'd10;

   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRACTION_BITS);
   localparam mag_type MAG_ONE = mag_type'(1) << FRACTION_BITS;
   localparam logic [32:0] POS_LIM = (FRACTION_BITS >= 15) ? 33'd32767 :
                                     ((33'd1 << FRACTION_BITS) - 33'd1);
   localparam logic [32:0] NEG_LIM = (FRACTION_BITS >= 15) ? 33'd32768 :
                                     (33'd1 << FRACTION_BITS);

   // clamp the magnitude and apply the sign
   function automatic dp_type sat_dp(input mag_type mag, input logic neg);
      logic [32:0] m;
      logic [32:0] s;
      m = 33'(mag);
      if (neg) begin
         s = (m > NEG_LIM) ? NEG_LIM : m;
         return dp_type'(DP_BITS'(0) - s[DP_BITS-1:0]);
      end else begin
         s = (m > POS_LIM) ? POS_LIM : m;
         return dp_type'(s[DP_BITS-1:0]);
      end
   endfunction

   // 4*x + 2*(y+z) + c4 in quarter-sample units
   function automatic wgt_type wgt_f(input count_type x, input count_type y,
                                     input count_type z, input count_type c4);
      return (wgt_type'(x) << 2) + ((wgt_type'(y) + wgt_type'(z)) << 1) + wgt_type'(c4);
   endfunction

   logic [3:0]           state_ff, state_in;
   count_type            counts_ff [CELLS];
   count_type            counts_in [CELLS];
   wgt_type              w0_ff, w1_ff, w2_ff, w3_ff, w0_in, w1_in, w2_in, w3_in;
   wgt_type              p0_ff, p1_ff, q0_ff, q1_ff, p0_in, p1_in, q0_in, q1_in;
   sum_type              n_ff, n_in, n_sum;
   prod_type             prod_ff, prod_in, a_ff, a_in, x_ff, x_in;
   prod_type             dabs_ff, dabs_in, den_ff, den_in, rem_ff, rem_in;
   logic                 pos_ff, pos_in;
   mag_type              quo_ff, quo_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   dp_type               dp_ff, dp_in;
   logic                 degen_ff, degen_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dp_type               rsp_dp_ff, rsp_dp_in;
   logic                 rsp_degen_ff, rsp_degen_in;
   vc_type               rsp_vc_ff, rsp_vc_in;

   wgt_type              mul_a, mul_b;
   logic                 in_xfer, out_xfer, present;
   logic [CELL_BITS-1:0] cell_idx;
   logic [PROD_BITS:0]   rem2;
   logic                 rem_ge;
   mag_type              quo_next;
   mag_type              mag_round;
   logic [NX_BITS-1:0]   n_x;
   vc_type               vc_sat;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.d_prime    = rsp_dp_ff;
   assign rsp_chan.degenerate = rsp_degen_ff;
   assign rsp_chan.valid_count = rsp_vc_ff;

   assign in_xfer  = req_chan.valid && req_chan.ready;
   assign out_xfer = rsp_valid_ff && rsp_chan.ready;
   assign present  = (req_chan.genotype_a != GENO_MISSING) &&
                     (req_chan.genotype_b != GENO_MISSING);
   assign cell_idx = CELL_BITS'(req_chan.genotype_a) + CELL_BITS'({req_chan.genotype_b, 1'b0})
                   + CELL_BITS'(req_chan.genotype_b);

   // total valid samples
   always_comb begin
      n_sum = '0;
      for (int i = 0; i < CELLS; i++) begin
         n_sum = n_sum + sum_type'(counts_ff[i]);
      end
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_MUL_A: begin
            mul_a = w0_ff;
            mul_b = w3_ff;
         end
         ST_MUL_B: begin
            mul_a = w1_ff;
            mul_b = w2_ff;
         end
         ST_MUL_X: begin
            mul_a = p0_ff;
            mul_b = pos_ff ? q1_ff : q0_ff;
         end
         ST_MUL_Y: begin
            mul_a = p1_ff;
            mul_b = pos_ff ? q0_ff : q1_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = prod_type'(mul_a) * prod_type'(mul_b);
   end

   // one restoring division step
   always_comb begin
      rem2      = {rem_ff, 1'b0};
      rem_ge    = (rem2 >= {1'b0, den_ff});
      quo_next  = {quo_ff[MAG_BITS-2:0], rem_ge};
      mag_round = mag_type'(({1'b0, quo_next} + {{MAG_BITS{1'b0}}, 1'b1}) >> 1);
   end

   // saturated sample count
   assign n_x    = NX_BITS'(n_ff);
   assign vc_sat = (n_x > NX_BITS'({VC_BITS{1'b1}})) ? '1 : n_x[VC_BITS-1:0];

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      counts_in    = counts_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      dabs_in      = dabs_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      dp_in        = dp_ff;
      degen_in     = degen_ff;
      rsp_valid_in = out_xfer ? 1'b0 : rsp_valid_ff;
      rsp_dp_in    = rsp_dp_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_vc_in    = rsp_vc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               if (present && (counts_ff[cell_idx] != '1)) begin
                  counts_in[cell_idx] = counts_ff[cell_idx] + count_type'(1);
               end
               if (req_chan.last_sample) begin
                  state_in = ST_WGT;
               end
            end
         end
         ST_WGT: begin
            w0_in    = wgt_f(counts_ff[0], counts_ff[1], counts_ff[3], counts_ff[4]);
            w1_in    = wgt_f(counts_ff[2], counts_ff[1], counts_ff[5], counts_ff[4]);
            w2_in    = wgt_f(counts_ff[6], counts_ff[3], counts_ff[7], counts_ff[4]);
            w3_in    = wgt_f(counts_ff[8], counts_ff[5], counts_ff[7], counts_ff[4]);
            p0_in    = w0_in + w1_in;
            p1_in    = w2_in + w3_in;
            q0_in    = w0_in + w2_in;
            q1_in    = w1_in + w3_in;
            n_in     = n_sum;
            dp_in    = '0;
            degen_in = 1'b0;
            if (n_sum == '0) begin
               degen_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            a_in     = prod_ff;
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            // prod_ff holds w1*w2 here
            pos_in  = (a_ff > prod_ff);
            dabs_in = (a_ff > prod_ff) ? (a_ff - prod_ff) : (prod_ff - a_ff);
            if (a_ff == prod_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            x_in     = prod_ff;
            state_in = ST_DMAX;
         end
         ST_DMAX: begin
            den_in   = (x_ff <= prod_ff) ? x_ff : prod_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               degen_in = 1'b1;
               state_in = ST_FINISH;
            end else if (dabs_ff >= den_ff) begin
               dp_in    = sat_dp(MAG_ONE, !pos_ff);
               state_in = ST_FINISH;
            end else begin
               rem_in   = dabs_ff;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? PROD_BITS'(rem2 - {1'b0, den_ff}) : rem2[PROD_BITS-1:0];
            quo_in  = quo_next;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_LAST) begin
               dp_in    = sat_dp(mag_round, !pos_ff);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // load the result once the output register is free
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_dp_in    = dp_ff;
               rsp_degen_in = degen_ff;
               rsp_vc_in    = vc_sat;
               for (int i = 0; i < CELLS; i++) begin
                  counts_in[i] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CELLS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      w0_ff        <= w0_in;
      w1_ff        <= w1_in;
      w2_ff        <= w2_in;
      w3_ff        <= w3_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      q0_ff        <= q0_in;
      q1_ff        <= q1_in;
      n_ff         <= n_in;
      prod_ff      <= prod_in;
      a_ff         <= a_in;
      x_ff         <= x_in;
      dabs_ff      <= dabs_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      pos_ff       <= pos_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      dp_ff        <= dp_in;
      degen_ff     <= degen_in;
      rsp_dp_ff    <= rsp_dp_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_vc_ff    <= rsp_vc_in;
   end

endmodule

/* design/ldd_checker.sv */
`timescale 1ns / 1ps

module ldd_checker import ldd_pkg::*; (
   input logic   clock,
   input logic   reset,
   input logic   req_valid,
   input logic   req_ready,
   input logic   req_last_sample,
   input logic   rsp_valid,
   input logic   rsp_ready,
   input dp_type d_prime,
   input logic   degenerate,
   input vc_type valid_count
);

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(d_prime) && $stable(degenerate)
                                  && $stable(valid_count))
      else $error("stalled result changed");

   // the final sample of a set starts the computation, so no sample follows at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_sample |=> !req_ready)
      else $error("sample taken right after the final sample");

   // a degenerate result reads zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> d_prime == '0)
      else $error("degenerate result with nonzero d_prime");

   // an empty sample set is always degenerate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && valid_count == '0 |-> degenerate)
      else $error("empty sample set not flagged degenerate");

endmodule

bind linkage_disequilibrium_dprime ldd_checker u_ldd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_last_sample (req_chan.last_sample),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .d_prime         (rsp_chan.d_prime),
   .degenerate      (rsp_chan.degenerate),
   .valid_count     (rsp_chan.valid_count)
);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ldd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_SAMPLES = 325;

   typedef struct {
      dp_type d_prime;
      logic   degenerate;
      vc_type valid_count;
   } dprime_result_type;

   logic clock;
   logic reset;

   ldd_req_if req_chan ();
   ldd_rsp_if rsp_chan ();

   linkage_disequilibrium_dprime dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state: nine joint genotype counts
   count_type         joint_tally [CELLS];
   dprime_result_type dprime_expected [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 0;
   int hold_left      = 0;

   int cycle_count     = 0;
   int error_count     = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int degenerate_seen = 0;
   int positive_seen   = 0;
   int negative_seen   = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run-time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // count one sample into the joint table, saturating
   function automatic void tally_genotypes(geno_type ga, geno_type gb);
      int k;
      if (ga != GENO_MISSING && gb != GENO_MISSING) begin
         k = int'(ga) + 3 * int'(gb);
         if (joint_tally[k] != {COUNT_BITS{1'b1}})
            joint_tally[k] = joint_tally[k] + 1'b1;
      end
   endfunction

   // D' from the joint table: exact integer D and Dmax, restoring division
   function automatic dprime_result_type predict_dprime();
      dprime_result_type        r;
      sum_type                  n;
      wgt_type                  w0, w1, w2, w3, p0, p1, q0, q1;
      prod_type                 ad, bc, dabs, dmax, alt;
      logic [PROD_BITS:0]       rem;
      int                       quo;
      int                       mag;
      r.d_prime     = '0;
      r.degenerate  = 1'b0;
      n = '0;
      for (int i = 0; i < CELLS; i++)
         n = n + sum_type'(joint_tally[i]);
      r.valid_count = (n > sum_type'(65535)) ? vc_type'(65535) : vc_type'(n);

      w0 = wgt_type'(4 * wgt_type'(joint_tally[0]) + 2 * (wgt_type'(joint_tally[1]) +
           wgt_type'(joint_tally[3])) + wgt_type'(joint_tally[4]));
      w1 = wgt_type'(4 * wgt_type'(joint_tally[2]) + 2 * (wgt_type'(joint_tally[1]) +
           wgt_type'(joint_tally[5])) + wgt_type'(joint_tally[4]));
      w2 = wgt_type'(4 * wgt_type'(joint_tally[6]) + 2 * (wgt_type'(joint_tally[3]) +
           wgt_type'(joint_tally[7])) + wgt_type'(joint_tally[4]));
      w3 = wgt_type'(4 * wgt_type'(joint_tally[8]) + 2 * (wgt_type'(joint_tally[5]) +
           wgt_type'(joint_tally[7])) + wgt_type'(joint_tally[4]));
      p0 = w0 + w1;
      p1 = w2 + w3;
      q0 = w0 + w2;
      q1 = w1 + w3;

      if (n == 0) begin
         r.degenerate = 1'b1;
      end else begin
         ad = prod_type'(w0) * prod_type'(w3);
         bc = prod_type'(w1) * prod_type'(w2);
         if (ad != bc) begin
            // Lewontin Dmax depends on the sign of D
            if (ad > bc) begin
               dabs = ad - bc;
               dmax = prod_type'(p0) * prod_type'(q1);
               alt  = prod_type'(p1) * prod_type'(q0);
            end else begin
               dabs = bc - ad;
               dmax = prod_type'(p0) * prod_type'(q0);
               alt  = prod_type'(p1) * prod_type'(q1);
            end
            if (alt < dmax)
               dmax = alt;
            if (dmax == 0) begin
               r.degenerate = 1'b1;
            end else begin
               if (dabs >= dmax) begin
                  mag = 1 << FRACTION_BITS;
               end else begin
                  // one extra quotient bit for round half away from zero
                  rem = {1'b0, dabs};
                  quo = 0;
                  for (int i = 0; i < FRACTION_BITS + 1; i++) begin
                     rem = rem << 1;
                     quo = quo << 1;
                     if (rem >= {1'b0, dmax}) begin
                        rem = rem - {1'b0, dmax};
                        quo = quo | 1;
                     end
                  end
                  mag = (quo + 1) >> 1;
               end
               if (ad > bc) begin
                  if (mag > (1 << FRACTION_BITS) - 1)
                     mag = (1 << FRACTION_BITS) - 1;
                  if (mag > 32767)
                     mag = 32767;
                  r.d_prime = dp_type'(mag);
               end else begin
                  if (mag > 32768)
                     mag = 32768;
                  r.d_prime = dp_type'(-mag);
               end
            end
         end
      end
      return r;
   endfunction

   // result receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      dprime_result_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (dprime_expected.size() == 0) begin
            $error("unexpected result: d_prime %0d degenerate %0b valid_count %0d",
                   rsp_chan.d_prime, rsp_chan.degenerate, rsp_chan.valid_count);
            error_count++;
         end else begin
            exp_r = dprime_expected.pop_front();
            results_checked++;
            if (exp_r.degenerate)
               degenerate_seen++;
            else if (exp_r.d_prime > 0)
               positive_seen++;
            else if (exp_r.d_prime < 0)
               negative_seen++;
            if (rsp_chan.d_prime !== exp_r.d_prime) begin
               $error("d_prime: expected %0d, got %0d", exp_r.d_prime, rsp_chan.d_prime);
               error_count++;
            end
            if (rsp_chan.degenerate !== exp_r.degenerate) begin
               $error("degenerate: expected %0b, got %0b",
                      exp_r.degenerate, rsp_chan.degenerate);
               error_count++;
            end
            if (rsp_chan.valid_count !== exp_r.valid_count) begin
               $error("valid_count: expected %0d, got %0d",
                      exp_r.valid_count, rsp_chan.valid_count);
               error_count++;
            end
         end
      end
   end

   // offer one sample at the falling edge and wait for its transfer
   task automatic send_genotypes(input geno_type ga, input geno_type gb, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.genotype_a  <= ga;
      req_chan.genotype_b  <= gb;
      req_chan.last_sample <= is_last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      samples_sent++;
      tally_genotypes(ga, gb);
      if (is_last) begin
         dprime_expected.push_back(predict_dprime());
         foreach (joint_tally[i])
            joint_tally[i] = '0;
      end
      @(negedge clock);
   endtask

   function automatic geno_type draw_code(int miss_pct);
      if ($urandom_range(99) < miss_pct)
         return GENO_MISSING;
      return geno_type'($urandom_range(2));
   endfunction

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // only missing calls: empty table
   task automatic test_no_valid_samples();
      send_genotypes(GENO_MISSING, 2'd0, 1'b0);
      send_genotypes(2'd0, GENO_MISSING, 1'b0);
      send_genotypes(GENO_MISSING, GENO_MISSING, 1'b1);
   endtask

   // every code pair once, missing ones included
   task automatic test_code_sweep();
      for (int b = 0; b < 4; b++)
         for (int a = 0; a < 4; a++)
            send_genotypes(geno_type'(a), geno_type'(b), (a == 3 && b == 3));
   endtask

   // complete linkage in both directions hits both saturation ends
   task automatic test_full_linkage();
      send_genotypes(2'd0, 2'd0, 1'b0);
      send_genotypes(2'd2, 2'd2, 1'b0);
      send_genotypes(2'd2, 2'd2, 1'b1);
      send_genotypes(2'd0, 2'd2, 1'b0);
      send_genotypes(2'd2, 2'd0, 1'b1);
   endtask

   // double heterozygote alone gives D of zero
   task automatic test_zero_disequilibrium();
      send_genotypes(2'd1, 2'd1, 1'b1);
   endtask

   // random marker pairs, mostly short, some correlated, a few all missing
   task automatic test_random_sets(int budget);
      int sent;
      int len;
      int mode;
      int miss;
      bit flip;
      geno_type ga;
      geno_type gb;
      sent = 0;
      while (sent < budget) begin
         len  = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 48);
         mode = $urandom_range(9);
         miss = $urandom_range(3) * 5;
         flip = $urandom_range(1);
         for (int i = 0; i < len; i++) begin
            if (mode == 9) begin
               ga = ($urandom_range(1)) ? GENO_MISSING : draw_code(0);
               gb = (ga == GENO_MISSING) ? geno_type'($urandom_range(3)) : GENO_MISSING;
            end else if (mode >= 6) begin
               ga = draw_code(miss);
               if (ga == GENO_MISSING || $urandom_range(99) < 20)
                  gb = draw_code(miss);
               else
                  gb = flip ? geno_type'(2 - int'(ga)) : ga;
            end else begin
               ga = draw_code(miss);
               gb = draw_code(miss);
            end
            send_genotypes(ga, gb, (i == len - 1));
         end
         sent += len;
      end
   endtask

   // receiver holds off while short sets keep coming, so the block backs up
   task automatic test_output_backpressure();
      int len;
      hold_request = 1;
      for (int s = 0; s < 40; s++) begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++)
            send_genotypes(draw_code(10), draw_code(10), (i == len - 1));
      end
   endtask

   // main sequence
   initial begin
      foreach (joint_tally[i])
         joint_tally[i] = '0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.genotype_a  = '0;
      req_chan.genotype_b  = '0;
      req_chan.last_sample = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_idling(0, 0);
      test_no_valid_samples();
      test_code_sweep();
      test_full_linkage();
      test_zero_disequilibrium();
      test_output_backpressure();

      set_idling(0, 0);
      test_random_sets(PHASE_SAMPLES);
      set_idling(79, 0);
      test_random_sets(PHASE_SAMPLES);
      set_idling(0, 79);
      test_random_sets(PHASE_SAMPLES);
      set_idling(19, 19);
      test_random_sets(PHASE_SAMPLES);

      // drain outstanding results
      req_chan.valid <= 1'b0;
      set_idling(0, 0);
      while (dprime_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d samples and %0d checked marker pairs in %0d cycles",
               samples_sent, results_checked, cycle_count);
      $display("results: %0d positive, %0d negative, %0d degenerate; %0d mismatches",
               positive_seen, negative_seen, degenerate_seen, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
